// File: src/swrc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_pkg
// Shared constants and types of the swept rectangle collision unit.
// ----------------------------------------------------------------------------
package swrc_pkg;

    localparam int FRAC_BITS_DEF = 16;  // fraction bits of every Q value
    localparam int POS_W         = 32;  // coordinate, velocity and result width
    localparam int ETIME_W       = 31;  // frame time width
    localparam int NORM_W        = 3;   // face normal code width

    // face normal codes
    localparam logic [NORM_W-1:0] NORM_NONE  = 3'd0;
    localparam logic [NORM_W-1:0] NORM_POS_X = 3'd1;
    localparam logic [NORM_W-1:0] NORM_NEG_X = 3'd2;
    localparam logic [NORM_W-1:0] NORM_POS_Y = 3'd3;
    localparam logic [NORM_W-1:0] NORM_NEG_Y = 3'd4;

    // per-item flags worked out ahead of the slab division
    typedef struct packed {
        logic miss;     // settled miss: no direction or origin outside a flat slab
        logic zero_x;   // x direction is zero, x slab is unbounded
        logic zero_y;   // y direction is zero, y slab is unbounded
    } t_flags;

endpackage

// File: src/swept_rect_vs_rect_collision_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swept_rect_vs_rect_collision_unit
// Swept rectangle versus fixed rectangle test by the ray-slab method: hit
// flag, contact point, face normal and near time for each item.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+----------------------------------------------
//  input   | i_valid / o_ready  | mover and target edges, velocity, frame time
//  output  | o_valid / i_ready  | hit, contact point, normal code, entry time
//
//  One item per cycle while the output is not stalled. The four slab dividers
//  resolve one quotient bit a stage.
//  Reset clears only the valid bits of the pipeline.
//  A stalled output holds the whole pipeline in place; o_ready is low only
//  while a finished item waits and i_ready is low.
// ----------------------------------------------------------------------------
module swept_rect_vs_rect_collision_unit #(
    parameter int FRAC_BITS = swrc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_mover_left,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_mover_top,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_mover_right,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_mover_bottom,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_target_left,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_target_top,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_target_right,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_target_bottom,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_vel_x,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_vel_y,
    input  logic        [swrc_pkg::ETIME_W-1:0] i_elapsed_time,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic signed [swrc_pkg::POS_W-1:0]   o_contact_x,
    output logic signed [swrc_pkg::POS_W-1:0]   o_contact_y,
    output logic        [swrc_pkg::NORM_W-1:0]  o_normal_code,
    output logic signed [swrc_pkg::POS_W-1:0]   o_entry_time
);

    localparam int NW  = 33 + FRAC_BITS;
    localparam int QW  = NW + 1;
    localparam int DW  = 64 - FRAC_BITS;
    localparam int FLW = $bits(swrc_pkg::t_flags);
    localparam int SBW = FLW + 2 * DW + 2 * swrc_pkg::POS_W;

    logic                               w_en;
    logic                               w_f_valid;
    logic signed [NW-1:0]               w_num_x0, w_num_x1, w_num_y0, w_num_y1;
    logic signed [DW-1:0]               w_dir_x, w_dir_y;
    logic signed [swrc_pkg::POS_W-1:0]  w_org_x, w_org_y;
    swrc_pkg::t_flags                   w_flags;
    logic signed [QW-1:0]               w_tx0, w_tx1, w_ty0, w_ty1;
    logic [SBW-1:0]                     w_sb_in, w_sb_out;
    logic                               w_d_valid;
    swrc_pkg::t_flags                   w_d_flags;
    logic signed [DW-1:0]               w_d_dir_x, w_d_dir_y;
    logic signed [swrc_pkg::POS_W-1:0]  w_d_org_x, w_d_org_y;

    // advance everything unless a finished item is held
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    swrc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid),
        .i_mover_left   (i_mover_left),
        .i_mover_top    (i_mover_top),
        .i_mover_right  (i_mover_right),
        .i_mover_bottom (i_mover_bottom),
        .i_target_left  (i_target_left),
        .i_target_top   (i_target_top),
        .i_target_right (i_target_right),
        .i_target_bottom(i_target_bottom),
        .i_vel_x        (i_vel_x),
        .i_vel_y        (i_vel_y),
        .i_elapsed_time (i_elapsed_time),
        .o_valid        (w_f_valid),
        .o_num_x0       (w_num_x0),
        .o_num_x1       (w_num_x1),
        .o_num_y0       (w_num_y0),
        .o_num_y1       (w_num_y1),
        .o_dir_x        (w_dir_x),
        .o_dir_y        (w_dir_y),
        .o_org_x        (w_org_x),
        .o_org_y        (w_org_y),
        .o_flags        (w_flags)
    );

    swrc_div_pipe #(.NW(NW), .DW(DW)) u_div_x0 (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_num_x0), .i_den(w_dir_x), .o_quo(w_tx0)
    );
    swrc_div_pipe #(.NW(NW), .DW(DW)) u_div_x1 (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_num_x1), .i_den(w_dir_x), .o_quo(w_tx1)
    );
    swrc_div_pipe #(.NW(NW), .DW(DW)) u_div_y0 (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_num_y0), .i_den(w_dir_y), .o_quo(w_ty0)
    );
    swrc_div_pipe #(.NW(NW), .DW(DW)) u_div_y1 (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_num_y1), .i_den(w_dir_y), .o_quo(w_ty1)
    );

    // carry the rest of the item alongside the dividers
    assign w_sb_in = {w_flags, w_dir_x, w_dir_y, w_org_x, w_org_y};

    swrc_delay #(.W(SBW), .DEPTH(NW + 2)) u_delay (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(w_f_valid),
        .i_data (w_sb_in),
        .o_valid(w_d_valid),
        .o_data (w_sb_out)
    );

    assign {w_d_flags, w_d_dir_x, w_d_dir_y, w_d_org_x, w_d_org_y} = w_sb_out;

    swrc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_d_valid),
        .i_tx0         (w_tx0),
        .i_tx1         (w_tx1),
        .i_ty0         (w_ty0),
        .i_ty1         (w_ty1),
        .i_flags       (w_d_flags),
        .i_dir_x       (w_d_dir_x),
        .i_dir_y       (w_d_dir_y),
        .i_org_x       (w_d_org_x),
        .i_org_y       (w_d_org_y),
        .o_valid       (o_valid),
        .o_hit         (o_hit),
        .o_contact_x   (o_contact_x),
        .o_contact_y   (o_contact_y),
        .o_normal_code (o_normal_code),
        .o_entry_time  (o_entry_time)
    );

endmodule

// File: src/swrc_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_delay
// Stall-aware delay line that carries item data and valid bits alongside
// the slab dividers.
// ----------------------------------------------------------------------------
module swrc_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [DEPTH-1:0] r_valid;
    logic [W-1:0]     r_data [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_data[i] <= r_data[i-1];
            end
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

endmodule

// File: src/swrc_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_div_pipe
// Pipelined signed divider, quotient truncated toward zero. One restoring
// step per stage; one item per cycle while i_en is high.
// ----------------------------------------------------------------------------
module swrc_div_pipe #(
    parameter int NW = 49,
    parameter int DW = 48
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [NW-1:0] i_num,
    input  logic signed [DW-1:0] i_den,
    output logic signed [NW:0]   o_quo
);

    logic [DW-1:0] r_rem [0:NW];
    logic [NW-1:0] r_nm  [0:NW];
    logic [NW-1:0] r_q   [0:NW];
    logic [DW-1:0] r_dm  [0:NW];
    logic          r_neg [0:NW];

    logic [NW-1:0] n_nm;
    logic [DW-1:0] n_dm;

    assign n_nm = i_num[NW-1] ? $unsigned(-i_num) : $unsigned(i_num);
    assign n_dm = i_den[DW-1] ? $unsigned(-i_den) : $unsigned(i_den);

    // take magnitudes and result sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_nm[0]  <= n_nm;
            r_q[0]   <= '0;
            r_dm[0]  <= n_dm;
            r_neg[0] <= i_num[NW-1] ^ i_den[DW-1];
        end
    end

    for (genvar s = 0; s < NW; s++) begin : g_step
        logic [DW:0] n_trial;
        logic        n_take;

        assign n_trial = {r_rem[s], r_nm[s][NW-1]};
        assign n_take  = (n_trial >= {1'b0, r_dm[s]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_take ? DW'(n_trial - {1'b0, r_dm[s]}) : n_trial[DW-1:0];
                r_nm[s+1]  <= {r_nm[s][NW-2:0], 1'b0};
                r_q[s+1]   <= {r_q[s][NW-2:0], n_take};
                r_dm[s+1]  <= r_dm[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    // apply sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo <= r_neg[NW] ? -$signed({1'b0, r_q[NW]}) : $signed({1'b0, r_q[NW]});
        end
    end

endmodule

// File: src/swrc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_front
// Front stages: scale velocity by frame time into a ray direction, form the
// slab numerators and the ray origin, flag items that cannot hit.
// ----------------------------------------------------------------------------
module swrc_front #(
    parameter int FRAC_BITS = swrc_pkg::FRAC_BITS_DEF,
    localparam int NW = 33 + FRAC_BITS,
    localparam int DW = 64 - FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_mover_left,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_mover_top,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_mover_right,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_mover_bottom,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_target_left,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_target_top,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_target_right,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_target_bottom,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_vel_x,
    input  logic signed [swrc_pkg::POS_W-1:0]    i_vel_y,
    input  logic        [swrc_pkg::ETIME_W-1:0]  i_elapsed_time,
    output logic                                 o_valid,
    output logic signed [NW-1:0]                 o_num_x0,
    output logic signed [NW-1:0]                 o_num_x1,
    output logic signed [NW-1:0]                 o_num_y0,
    output logic signed [NW-1:0]                 o_num_y1,
    output logic signed [DW-1:0]                 o_dir_x,
    output logic signed [DW-1:0]                 o_dir_y,
    output logic signed [swrc_pkg::POS_W-1:0]    o_org_x,
    output logic signed [swrc_pkg::POS_W-1:0]    o_org_y,
    output swrc_pkg::t_flags                     o_flags
);

    localparam logic [63:0] RND = (64'd1 << FRAC_BITS) - 64'd1;

    // stage 1
    logic                r_v1;
    logic signed [63:0]  r_px, r_py;
    logic signed [32:0]  r1_ax0, r1_ax1, r1_ay0, r1_ay1;
    logic signed [31:0]  r1_ox, r1_oy;
    // stage 2
    logic                r_v2;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [32:0]  r2_ax0, r2_ax1, r2_ay0, r2_ay1;
    logic signed [31:0]  r2_ox, r2_oy;

    logic signed [32:0]  n_sx, n_sy;
    logic signed [63:0]  n_pxa, n_pya;
    logic                n_out_x, n_out_y;

    assign n_sx = $signed({i_mover_left[31], i_mover_left})
                + $signed({i_mover_right[31], i_mover_right});
    assign n_sy = $signed({i_mover_top[31], i_mover_top})
                + $signed({i_mover_bottom[31], i_mover_bottom});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // target edge widened by the mover half size, minus center, reduces to target edge minus far mover edge
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= i_vel_x * $signed({1'b0, i_elapsed_time});
            r_py   <= i_vel_y * $signed({1'b0, i_elapsed_time});
            r1_ax0 <= $signed({i_target_left[31], i_target_left})
                    - $signed({i_mover_right[31], i_mover_right});
            r1_ax1 <= $signed({i_target_right[31], i_target_right})
                    - $signed({i_mover_left[31], i_mover_left});
            r1_ay0 <= $signed({i_target_top[31], i_target_top})
                    - $signed({i_mover_bottom[31], i_mover_bottom});
            r1_ay1 <= $signed({i_target_bottom[31], i_target_bottom})
                    - $signed({i_mover_top[31], i_mover_top});
            r1_ox  <= n_sx[32:1];
            r1_oy  <= n_sy[32:1];
        end
    end

    // round the scaled direction toward zero
    assign n_pxa = r_px + (r_px[63] ? $signed(RND) : 64'sd0);
    assign n_pya = r_py + (r_py[63] ? $signed(RND) : 64'sd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_pxa[63:FRAC_BITS];
            r_dy   <= n_pya[63:FRAC_BITS];
            r2_ax0 <= r1_ax0;
            r2_ax1 <= r1_ax1;
            r2_ay0 <= r1_ay0;
            r2_ay1 <= r1_ay1;
            r2_ox  <= r1_ox;
            r2_oy  <= r1_oy;
        end
    end

    // origin outside a flat slab: both edge offsets on the same side
    assign n_out_x = (!r2_ax0[32] && r2_ax0 != '0 && !r2_ax1[32] && r2_ax1 != '0)
                  || (r2_ax0[32] && r2_ax1[32]);
    assign n_out_y = (!r2_ay0[32] && r2_ay0 != '0 && !r2_ay1[32] && r2_ay1 != '0)
                  || (r2_ay0[32] && r2_ay1[32]);

    always_comb begin
        o_flags.zero_x = (r_dx == '0);
        o_flags.zero_y = (r_dy == '0);
        o_flags.miss   = (o_flags.zero_x && o_flags.zero_y)
                      || (o_flags.zero_x && n_out_x)
                      || (o_flags.zero_y && n_out_y);
    end

    assign o_valid  = r_v2;
    assign o_num_x0 = $signed({r2_ax0, {FRAC_BITS{1'b0}}});
    assign o_num_x1 = $signed({r2_ax1, {FRAC_BITS{1'b0}}});
    assign o_num_y0 = $signed({r2_ay0, {FRAC_BITS{1'b0}}});
    assign o_num_y1 = $signed({r2_ay1, {FRAC_BITS{1'b0}}});
    assign o_dir_x  = r_dx;
    assign o_dir_y  = r_dy;
    assign o_org_x  = r2_ox;
    assign o_org_y  = r2_oy;

endmodule

// File: src/swrc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrc_back
// Back stages: order slab times, test interval overlap and frame window,
// pick the face normal, and scale the direction by the near time for the
// contact point with a split saturating multiply.
// ----------------------------------------------------------------------------
module swrc_back #(
    parameter int FRAC_BITS = swrc_pkg::FRAC_BITS_DEF,
    localparam int NW = 33 + FRAC_BITS,
    localparam int QW = NW + 1,
    localparam int DW = 64 - FRAC_BITS,
    localparam int DH = DW - 32,
    localparam int TH = NW - 32,
    localparam int PW = DW + NW
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [QW-1:0]                i_tx0,
    input  logic signed [QW-1:0]                i_tx1,
    input  logic signed [QW-1:0]                i_ty0,
    input  logic signed [QW-1:0]                i_ty1,
    input  swrc_pkg::t_flags                    i_flags,
    input  logic signed [DW-1:0]                i_dir_x,
    input  logic signed [DW-1:0]                i_dir_y,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_org_x,
    input  logic signed [swrc_pkg::POS_W-1:0]   i_org_y,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic signed [swrc_pkg::POS_W-1:0]   o_contact_x,
    output logic signed [swrc_pkg::POS_W-1:0]   o_contact_y,
    output logic        [swrc_pkg::NORM_W-1:0]  o_normal_code,
    output logic signed [swrc_pkg::POS_W-1:0]   o_entry_time
);

    localparam int NSTG = 8;
    localparam logic signed [63:0] UNB = 64'sh4000_0000_0000_0000;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic [PW-1:0]      SAT = PW'(64'h4000_0000_0000_0000);

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sh0000_0000_7FFF_FFFF) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (x < -64'sh0000_0000_8000_0000) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

    function automatic logic signed [63:0] sext(input logic signed [QW-1:0] q);
        sext = {{(64-QW){q[QW-1]}}, q};
    endfunction

    logic [NSTG:1] r_v;

    // stage 1
    logic signed [63:0] r1_tn [0:1];
    logic signed [63:0] r1_tf [0:1];
    logic               r1_miss;
    logic [DW-1:0]      r1_dm [0:1];
    logic               r1_dneg [0:1];
    logic signed [31:0] r1_org [0:1];
    // stage 2
    logic               r2_miss;
    logic signed [63:0] r2_tnear, r2_tfar;
    logic [2:0]         r2_norm;
    logic [DW-1:0]      r2_dm [0:1];
    logic               r2_dneg [0:1];
    logic signed [31:0] r2_org [0:1];
    // stage 3
    logic               r3_hit;
    logic signed [31:0] r3_ctime;
    logic [2:0]         r3_norm;
    logic [NW-1:0]      r3_tm;
    logic [DW-1:0]      r3_dm [0:1];
    logic               r3_neg [0:1];
    logic signed [31:0] r3_org [0:1];
    // stage 4
    logic               r4_hit;
    logic signed [31:0] r4_ctime;
    logic [2:0]         r4_norm;
    logic [63:0]        r4_pp0 [0:1];
    logic [31+TH:0]     r4_pp1 [0:1];
    logic [DH+31:0]     r4_pp2 [0:1];
    logic [DH+TH-1:0]   r4_pp3 [0:1];
    logic               r4_neg [0:1];
    logic signed [31:0] r4_org [0:1];
    // stage 5
    logic               r5_hit;
    logic signed [31:0] r5_ctime;
    logic [2:0]         r5_norm;
    logic [63:0]        r5_pp0 [0:1];
    logic [PW-33:0]     r5_mid [0:1];
    logic [DH+TH-1:0]   r5_pp3 [0:1];
    logic               r5_neg [0:1];
    logic signed [31:0] r5_org [0:1];
    // stage 6
    logic               r6_hit;
    logic signed [31:0] r6_ctime;
    logic [2:0]         r6_norm;
    logic [PW-1:0]      r6_full [0:1];
    logic               r6_neg [0:1];
    logic signed [31:0] r6_org [0:1];
    // stage 7
    logic               r7_hit;
    logic signed [31:0] r7_ctime;
    logic [2:0]         r7_norm;
    logic signed [63:0] r7_sval [0:1];
    logic signed [31:0] r7_org [0:1];

    logic signed [63:0] n_ta [0:1];
    logic signed [63:0] n_tb [0:1];
    logic               n_zero [0:1];
    logic signed [DW-1:0] n_dir [0:1];
    logic signed [63:0] n_tabs;
    logic [62:0]        n_mag [0:1];
    logic [62:0]        n_q [0:1];

    assign n_ta[0]   = sext(i_tx0);
    assign n_tb[0]   = sext(i_tx1);
    assign n_ta[1]   = sext(i_ty0);
    assign n_tb[1]   = sext(i_ty1);
    assign n_zero[0] = i_flags.zero_x;
    assign n_zero[1] = i_flags.zero_y;
    assign n_dir[0]  = i_dir_x;
    assign n_dir[1]  = i_dir_y;
    assign n_tabs    = r2_tnear[63] ? -r2_tnear : r2_tnear;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_mag[a] = (r6_full[a] > SAT) ? {1'b1, 62'd0} : r6_full[a][62:0];
            n_q[a]   = n_mag[a] >> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NSTG-1:1], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: order each slab, open it wide on a zero direction
            r1_miss <= i_flags.miss;
            r1_org[0] <= i_org_x;
            r1_org[1] <= i_org_y;
            for (int a = 0; a < 2; a++) begin
                if (n_zero[a]) begin
                    r1_tn[a] <= -UNB;
                    r1_tf[a] <= UNB;
                end else if (n_ta[a] > n_tb[a]) begin
                    r1_tn[a] <= n_tb[a];
                    r1_tf[a] <= n_ta[a];
                end else begin
                    r1_tn[a] <= n_ta[a];
                    r1_tf[a] <= n_tb[a];
                end
                r1_dm[a]   <= n_dir[a][DW-1] ? $unsigned(-n_dir[a]) : $unsigned(n_dir[a]);
                r1_dneg[a] <= n_dir[a][DW-1];
            end

            // stage 2: overlap, near and far times, face normal
            r2_miss  <= r1_miss || (r1_tn[0] > r1_tf[1]) || (r1_tn[1] > r1_tf[0]);
            r2_tnear <= (r1_tn[0] > r1_tn[1]) ? r1_tn[0] : r1_tn[1];
            r2_tfar  <= (r1_tf[0] < r1_tf[1]) ? r1_tf[0] : r1_tf[1];
            if (r1_tn[0] > r1_tn[1]) begin
                r2_norm <= r1_dneg[0] ? swrc_pkg::NORM_POS_X : swrc_pkg::NORM_NEG_X;
            end else if (r1_tn[0] < r1_tn[1]) begin
                r2_norm <= r1_dneg[1] ? swrc_pkg::NORM_POS_Y : swrc_pkg::NORM_NEG_Y;
            end else begin
                r2_norm <= swrc_pkg::NORM_NONE;
            end
            r2_dm   <= r1_dm;
            r2_dneg <= r1_dneg;
            r2_org  <= r1_org;

            // stage 3: frame window, operands of the contact multiply
            r3_hit   <= !r2_miss && !r2_tfar[63] && !(r2_tnear > ONE);
            r3_ctime <= sat32(r2_tnear);
            r3_norm  <= r2_norm;
            r3_tm    <= n_tabs[NW-1:0];
            r3_dm    <= r2_dm;
            r3_org   <= r2_org;
            for (int a = 0; a < 2; a++) begin
                r3_neg[a] <= r2_dneg[a] ^ r2_tnear[63];
            end

            // stage 4: partial products
            r4_hit   <= r3_hit;
            r4_ctime <= r3_ctime;
            r4_norm  <= r3_norm;
            r4_neg   <= r3_neg;
            r4_org   <= r3_org;
            for (int a = 0; a < 2; a++) begin
                r4_pp0[a] <= r3_dm[a][31:0] * r3_tm[31:0];
                r4_pp1[a] <= r3_dm[a][31:0] * r3_tm[NW-1:32];
                r4_pp2[a] <= r3_dm[a][DW-1:32] * r3_tm[31:0];
                r4_pp3[a] <= r3_dm[a][DW-1:32] * r3_tm[NW-1:32];
            end

            // stage 5: middle terms
            r5_hit   <= r4_hit;
            r5_ctime <= r4_ctime;
            r5_norm  <= r4_norm;
            r5_neg   <= r4_neg;
            r5_org   <= r4_org;
            r5_pp0   <= r4_pp0;
            r5_pp3   <= r4_pp3;
            for (int a = 0; a < 2; a++) begin
                r5_mid[a] <= (PW-32)'(r4_pp1[a]) + (PW-32)'(r4_pp2[a]);
            end

            // stage 6: full product
            r6_hit   <= r5_hit;
            r6_ctime <= r5_ctime;
            r6_norm  <= r5_norm;
            r6_neg   <= r5_neg;
            r6_org   <= r5_org;
            for (int a = 0; a < 2; a++) begin
                r6_full[a] <= PW'(r5_pp0[a]) + {r5_mid[a], 32'd0} + {r5_pp3[a], 64'd0};
            end

            // stage 7: saturate, scale down, apply sign
            r7_hit   <= r6_hit;
            r7_ctime <= r6_ctime;
            r7_norm  <= r6_norm;
            r7_org   <= r6_org;
            for (int a = 0; a < 2; a++) begin
                r7_sval[a] <= r6_neg[a] ? -$signed({1'b0, n_q[a]}) : $signed({1'b0, n_q[a]});
            end

            // stage 8: add origin, drop everything on a miss
            o_hit          <= r7_hit;
            o_normal_code  <= r7_hit ? r7_norm : swrc_pkg::NORM_NONE;
            o_entry_time   <= r7_hit ? r7_ctime : 32'sd0;
            o_contact_x    <= r7_hit ? sat32({{32{r7_org[0][31]}}, r7_org[0]} + r7_sval[0])
                                     : 32'sd0;
            o_contact_y    <= r7_hit ? sat32({{32{r7_org[1][31]}}, r7_org[1]} + r7_sval[1])
                                     : 32'sd0;
        end
    end

    assign o_valid = r_v[NSTG];

endmodule
